### design/tlb_pkg.sv
// Package of shared types, constants and codes for the translation buffer.
`default_nettype none
package tlb_pkg;
	localparam int MAX_ENTRIES = 16;
	localparam int SLOT_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	localparam logic [1:0] MODE_TRANSLATE = 2'd0;
	localparam logic [1:0] MODE_FILL      = 2'd1;
	localparam logic [1:0] MODE_FLUSH     = 2'd2;
	localparam logic [1:0] MODE_UNUSED    = 2'd3;

	localparam logic [1:0] REG_PAGE_SIZE = 2'd0;
	localparam logic [1:0] REG_PER_TABLE = 2'd1;
	localparam logic [1:0] REG_POLICY    = 2'd2;
	localparam logic [1:0] REG_IN_USE    = 2'd3;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] logical_address;
		logic [19:0] fill_frame;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] physical_address;
		logic [31:0] first_level_index;
		logic [9:0]  second_level_index;
		logic [3:0]  written_slot;
	} rsp_t;

	typedef struct packed {
		logic load;      // capture request, start first division
		logic div2;      // start second division
		logic scan;      // advance one slot of the search
		logic finish;    // commit state update and result
		logic mul;       // start the frame multiply
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic scan_last;
		logic [1:0] mode;
	} sts_t;
endpackage
`default_nettype wire

### design/tlb_if.sv
// Valid/ready channel interfaces for requests, responses and configuration.
`default_nettype none
interface tlb_req_if;
	logic valid;
	logic ready;
	tlb_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tlb_rsp_if;
	logic valid;
	logic ready;
	tlb_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tlb_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [31:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### design/tlb_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
module tlb_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [16:0] divisor,
	output logic             done,
	output logic [31:0]      quotient,
	output logic [16:0]      remainder
);
	logic [31:0] quo_q;
	logic [16:0] rem_q;
	logic [16:0] dsr_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [17:0] trial;

	assign trial = {rem_q, quo_q[31]} - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'd32;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[17]) begin
				rem_q <= trial[16:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[15:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign done = busy_q && (cnt_q == 6'd1);
	assign quotient = quo_q;
	assign remainder = rem_q;
endmodule
`default_nettype wire

### design/tlb_datapath.sv
// Datapath: address split, slot storage, serial search and result register.
`default_nettype none
module tlb_datapath (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire tlb_pkg::cmd_t cmd,
	output tlb_pkg::sts_t    sts,
	input  wire tlb_pkg::req_t req,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	output tlb_pkg::rsp_t    rsp
);
	localparam int SW = tlb_pkg::SLOT_W;
	localparam int N = tlb_pkg::MAX_ENTRIES;
	localparam int CNT_W_L = tlb_pkg::CNT_W;

	logic [16:0] page_size_q;
	logic [10:0] per_table_q;
	logic        policy_q;
	logic [4:0]  in_use_q;

	logic [N-1:0]  valid_q;
	logic [31:0]   page_mem [N];
	logic [19:0]   frame_mem [N];
	logic [31:0]   created_mem [N];
	logic [31:0]   used_mem [N];
	logic [31:0]   counter_q;

	tlb_pkg::req_t req_q;
	logic [31:0] page_q;
	logic [16:0] offset_q;
	logic [31:0] first_q;
	logic [9:0]  second_q;
	logic        second_phase_q;
	logic [SW-1:0] idx_q;
	logic        hit_found_q, same_found_q, empty_found_q;
	logic [SW-1:0] hit_slot_q, same_slot_q, empty_slot_q, old_slot_q;
	logic [31:0]   old_age_q;
	logic [31:0]   prod_q;

	logic [16:0] ps_eff;
	logic [16:0] ept_eff;
	logic [CNT_W_L-1:0] used_eff;

	always_comb begin
		ps_eff = (page_size_q == '0) ? 17'd1 : (page_size_q > 17'd65536) ? 17'd65536
			: page_size_q;
		ept_eff = (per_table_q == '0) ? 17'd1 : (per_table_q > 11'd1024) ? 17'd1024
			: {6'd0, per_table_q};
		used_eff = (in_use_q == '0) ? CNT_W_L'(1) : (in_use_q > 5'(N)) ? CNT_W_L'(N)
			: CNT_W_L'(in_use_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_size_q <= 17'd64;
			per_table_q <= 11'd4;
			policy_q    <= 1'b0;
			in_use_q    <= 5'd4;
		end else if (cfg_we) begin
			case (cfg_index)
				tlb_pkg::REG_PAGE_SIZE: page_size_q <= cfg_data[16:0];
				tlb_pkg::REG_PER_TABLE: per_table_q <= cfg_data[10:0];
				tlb_pkg::REG_POLICY:    policy_q <= cfg_data[0];
				tlb_pkg::REG_IN_USE:    in_use_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	logic div_start, div_done;
	logic [31:0] div_q;
	logic [16:0] div_r;

	assign div_start = cmd.load || cmd.div2;

	tlb_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(cmd.load ? req.logical_address : div_q),
		.divisor(cmd.load ? ps_eff : ept_eff),
		.done(div_done), .quotient(div_q), .remainder(div_r)
	);

	// The divider's done pulse comes while its final register update is still pending.
	// A restart drops a done pulse left over from an abandoned division.
	logic div_fin_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) div_fin_q <= 1'b0;
		else div_fin_q <= div_done && !div_start;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
			second_phase_q <= 1'b0;
		end else if (div_fin_q && !second_phase_q) begin
			page_q <= div_q;
			offset_q <= div_r;
			second_phase_q <= 1'b1;
		end else if (div_fin_q) begin
			first_q <= div_q;
			second_q <= div_r[9:0];
		end
	end

	logic [SW-1:0] rd_idx;
	logic [31:0] age;
	assign rd_idx = idx_q;
	assign age = counter_q - (policy_q ? used_mem[rd_idx] : created_mem[rd_idx]);

	always_ff @(posedge clk) begin
		if (cmd.div2) begin
			idx_q <= '0;
			hit_found_q <= 1'b0;
			same_found_q <= 1'b0;
			empty_found_q <= 1'b0;
			hit_slot_q <= '0;
			old_slot_q <= '0;
			old_age_q <= '0;
		end else if (cmd.scan) begin
			if (valid_q[rd_idx] && page_mem[rd_idx] == page_q && !hit_found_q) begin
				hit_found_q <= 1'b1;
				hit_slot_q <= rd_idx;
			end
			if (valid_q[rd_idx] && frame_mem[rd_idx] == req_q.fill_frame && !same_found_q) begin
				same_found_q <= 1'b1;
				same_slot_q <= rd_idx;
			end
			if (!valid_q[rd_idx] && !empty_found_q) begin
				empty_found_q <= 1'b1;
				empty_slot_q <= rd_idx;
			end
			if (rd_idx == '0 || age > old_age_q) begin
				old_slot_q <= rd_idx;
				old_age_q <= age;
			end
			idx_q <= idx_q + SW'(1);
		end
	end

	assign sts.scan_last = ({1'b0, idx_q} == CNT_W_L'(used_eff - CNT_W_L'(1)));
	assign sts.div_done = div_fin_q && second_phase_q;
	assign sts.mode = req_q.mode;

	logic [SW-1:0] victim;
	assign victim = same_found_q ? same_slot_q : empty_found_q ? empty_slot_q : old_slot_q;

	logic [19:0] mul_frame;
	assign mul_frame = (req_q.mode == tlb_pkg::MODE_FILL) ? req_q.fill_frame
		: frame_mem[hit_slot_q];

	always_ff @(posedge clk) begin
		if (cmd.mul) prod_q <= 32'(mul_frame * ps_eff) + {15'd0, offset_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			counter_q <= '0;
		end else if (cmd.finish) begin
			case (req_q.mode)
				tlb_pkg::MODE_TRANSLATE: counter_q <= counter_q + 32'd1;
				tlb_pkg::MODE_FILL: begin
					counter_q <= counter_q + 32'd1;
					valid_q[victim] <= 1'b1;
				end
				tlb_pkg::MODE_FLUSH: valid_q <= '0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish && req_q.mode == tlb_pkg::MODE_FILL) begin
			page_mem[victim] <= page_q;
			frame_mem[victim] <= req_q.fill_frame;
			created_mem[victim] <= counter_q;
			used_mem[victim] <= counter_q;
		end else if (cmd.finish && req_q.mode == tlb_pkg::MODE_TRANSLATE && hit_found_q) begin
			used_mem[hit_slot_q] <= counter_q;
		end
	end

	tlb_pkg::rsp_t rsp_next;
	always_comb begin
		rsp_next = '0;
		case (req_q.mode)
			tlb_pkg::MODE_TRANSLATE: begin
				rsp_next.first_level_index = first_q;
				rsp_next.second_level_index = second_q;
				if (hit_found_q) begin
					rsp_next.hit = 1'b1;
					rsp_next.physical_address = prod_q;
					rsp_next.written_slot = 4'(hit_slot_q);
				end
			end
			tlb_pkg::MODE_FILL: begin
				rsp_next.first_level_index = first_q;
				rsp_next.second_level_index = second_q;
				rsp_next.physical_address = prod_q;
				rsp_next.written_slot = 4'(victim);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) rsp <= rsp_next;
	end
endmodule
`default_nettype wire

### design/tlb_ctrl.sv
// Controller: sequences division, search, multiply and result handoff.
`default_nettype none
module tlb_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	output tlb_pkg::cmd_t cmd,
	input  wire tlb_pkg::sts_t sts
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV1 = 3'd1;
	localparam logic [2:0] S_DIV2 = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_MUL  = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0] state_q;
	logic       first_div_q;
	logic [5:0] wait_q;
	logic       page_ready_q;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd = '0;
		cmd.load = in_valid && in_ready;
		cmd.div2 = (state_q == S_DIV1) && first_div_q;
		cmd.scan = (state_q == S_SCAN);
		cmd.mul = (state_q == S_MUL);
		cmd.finish = (state_q == S_FIN);
	end

	// S_DIV1 waits out the page split, then the second split runs to div_done; other modes go to S_FIN.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			first_div_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) begin
					state_q <= S_DIV1;
					first_div_q <= 1'b0;
				end
				S_DIV1: begin
					if (first_div_q) state_q <= S_DIV2;
					else if (!(sts.mode inside {tlb_pkg::MODE_TRANSLATE, tlb_pkg::MODE_FILL}))
						state_q <= S_FIN;
					first_div_q <= !first_div_q && page_ready_q;
				end
				S_DIV2: if (sts.div_done) state_q <= S_SCAN;
				S_SCAN: if (sts.scan_last) state_q <= S_MUL;
				S_MUL: state_q <= S_FIN;
				S_FIN: state_q <= S_OUT;
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// A countdown from load raises page_ready_q when the page split completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_q <= '0;
			page_ready_q <= 1'b0;
		end else if (cmd.load) begin
			wait_q <= 6'd33;
			page_ready_q <= 1'b0;
		end else if (wait_q != '0) begin
			wait_q <= wait_q - 6'd1;
			page_ready_q <= (wait_q == 6'd1);
		end else page_ready_q <= 1'b0;
	end
endmodule
`default_nettype wire

### design/tlb_fifo_lru_translate.sv
// Top level of the translation buffer with FIFO or LRU replacement.
// Each item is taken alone: an address split by page size, a split of the
// page number by entries per table, a serial search over the entries in use,
// a multiply and a commit, with the time set mostly by the shared bit-serial
// divider; a flush or an unused mode does not wait for the splits and skips
// the search and the multiply.
// The result register holds until taken.
`default_nettype none
module tlb_fifo_lru_translate (
	input wire logic clk,
	input wire logic arst_n,
	tlb_req_if.sink   req,
	tlb_rsp_if.source rsp,
	tlb_cfg_if.sink   cfg
);
	tlb_pkg::cmd_t cmd;
	tlb_pkg::sts_t sts;

	assign cfg.ready = 1'b1;

	tlb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(req.valid), .in_ready(req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready), .cmd(cmd), .sts(sts)
	);

	tlb_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .req(req.data),
		.cfg_we(cfg.valid), .cfg_index(cfg.index), .cfg_data(cfg.data),
		.rsp(rsp.data)
	);
endmodule
`default_nettype wire

### design/tlb_checker.sv
// Port-level checker for the translation buffer, bound to the top level.
`default_nettype none
module tlb_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire tlb_pkg::rsp_t rsp_data
);
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready) else $error("request taken while result pending");
	a_accept_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !rsp_valid) else $error("result without work");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_data))
		else $error("result dropped");
endmodule

bind tlb_fifo_lru_translate tlb_checker u_chk (
	.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
`default_nettype wire

### tb/tb_tlb_fifo_lru_translate.sv
// Self-checking testbench for the translation buffer: directed and random traffic against a built-in predictor.
`timescale 1ns / 1ps
module tb_tlb_fifo_lru_translate;
	logic clk;
	logic arst_n;

	tlb_req_if req();
	tlb_rsp_if rsp();
	tlb_cfg_if cfg();

	tlb_fifo_lru_translate u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg(cfg)
	);

	// Predictor state.
	logic [16:0] pg_size_reg;
	logic [10:0] per_table_reg;
	logic        policy_reg;
	logic [4:0]  in_use_reg;
	logic        tv_valid [tlb_pkg::MAX_ENTRIES];
	logic [31:0] tv_page [tlb_pkg::MAX_ENTRIES];
	logic [19:0] tv_frame [tlb_pkg::MAX_ENTRIES];
	logic [31:0] tv_born [tlb_pkg::MAX_ENTRIES];
	logic [31:0] tv_touch [tlb_pkg::MAX_ENTRIES];
	logic [31:0] evt_count;

	tlb_pkg::req_t pending_reqs[$];
	tlb_pkg::rsp_t expected_rsps[$];
	int   errors;
	int   cycles;
	int   recv_wait;
	int   gap_left;

	// Configuration requests from the stimulus thread to the driver.
	logic       cfg_go;
	logic [1:0] cfg_idx;
	logic [31:0] cfg_val;

	// Handshakes seen at the rising edge, used by the falling-edge drivers.
	logic req_taken;
	logic cfg_taken;
	logic rsp_taken;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic tlb_pkg::rsp_t predict_lookup(tlb_pkg::req_t r);
		tlb_pkg::rsp_t o;
		logic [31:0] ps, ept, used, page, offset, best_age, age, st;
		int slot;
		o = '0;
		ps = (pg_size_reg == 0) ? 1 : (pg_size_reg > 65536) ? 65536 : pg_size_reg;
		ept = (per_table_reg == 0) ? 1 : (per_table_reg > 1024) ? 1024 : per_table_reg;
		used = (in_use_reg == 0) ? 1 : (in_use_reg > tlb_pkg::MAX_ENTRIES) ?
			tlb_pkg::MAX_ENTRIES : in_use_reg;
		page = r.logical_address / ps;
		offset = r.logical_address - page * ps;
		if (r.mode == tlb_pkg::MODE_TRANSLATE) begin
			o.first_level_index = page / ept;
			o.second_level_index = 10'(page % ept);
			for (int i = 0; i < used; i++) begin
				if (tv_valid[i] && tv_page[i] == page) begin
					o.hit = 1'b1;
					o.written_slot = 4'(i);
					tv_touch[i] = evt_count;
					o.physical_address = 32'(tv_frame[i]) * ps + offset;
					break;
				end
			end
			evt_count = evt_count + 1;
		end else if (r.mode == tlb_pkg::MODE_FILL) begin
			o.first_level_index = page / ept;
			o.second_level_index = 10'(page % ept);
			slot = -1;
			for (int i = 0; i < used; i++)
				if (slot < 0 && tv_valid[i] && tv_frame[i] == r.fill_frame) slot = i;
			for (int i = 0; i < used; i++)
				if (slot < 0 && !tv_valid[i]) slot = i;
			if (slot < 0) begin
				best_age = 0;
				for (int i = 0; i < used; i++) begin
					st = policy_reg ? tv_touch[i] : tv_born[i];
					age = evt_count - st;
					if (i == 0 || age > best_age) begin
						slot = i;
						best_age = age;
					end
				end
			end
			tv_valid[slot] = 1'b1;
			tv_page[slot] = page;
			tv_frame[slot] = r.fill_frame;
			tv_born[slot] = evt_count;
			tv_touch[slot] = evt_count;
			o.physical_address = 32'(r.fill_frame) * ps + offset;
			o.written_slot = 4'(slot);
			evt_count = evt_count + 1;
		end else if (r.mode == tlb_pkg::MODE_FLUSH) begin
			for (int i = 0; i < tlb_pkg::MAX_ENTRIES; i++) tv_valid[i] = 1'b0;
		end
		return o;
	endfunction

	// Acceptance is resolved at the rising edge; the next drive is at the falling edge.
	always @(posedge clk) begin
		req_taken <= arst_n && req.valid && req.ready;
		cfg_taken <= arst_n && cfg.valid && cfg.ready;
		rsp_taken <= arst_n && rsp.valid && rsp.ready;
		if (arst_n && req.valid && req.ready)
			expected_rsps.push_back(predict_lookup(req.data));
		if (arst_n && cfg.valid && cfg.ready) begin
			case (cfg.index)
				tlb_pkg::REG_PAGE_SIZE: pg_size_reg = cfg.data[16:0];
				tlb_pkg::REG_PER_TABLE: per_table_reg = cfg.data[10:0];
				tlb_pkg::REG_POLICY:    policy_reg = cfg.data[0];
				tlb_pkg::REG_IN_USE:    in_use_reg = cfg.data[4:0];
				default: ;
			endcase
		end
	end

	// Driver: request and configuration channels, changed on the falling edge.
	always @(negedge clk) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			cfg.valid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (cfg_taken) cfg.valid <= 1'b0;
			else if (cfg_go && !cfg.valid) begin
				cfg.valid <= 1'b1;
				cfg.index <= cfg_idx;
				cfg.data <= cfg_val;
			end
			if (req.valid && !req_taken) begin
				// Hold the transaction until it is taken.
			end else if (gap_left > 0) begin
				req.valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_reqs.size() > 0) begin
				req.valid <= 1'b1;
				req.data <= pending_reqs.pop_front();
				gap_left <= $urandom_range(0, 9);
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// Monitor: compare each response with the oldest expectation.
	always @(posedge clk) begin
		tlb_pkg::rsp_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_rsps.size() == 0) begin
				$display("%0t: unexpected response %h", $time, rsp.data);
				errors++;
			end else begin
				e = expected_rsps.pop_front();
				if (rsp.data.hit !== e.hit) begin
					$display("%0t: hit expected %h actual %h", $time, e.hit, rsp.data.hit);
					errors++;
				end
				if (rsp.data.physical_address !== e.physical_address) begin
					$display("%0t: physical_address expected %h actual %h", $time,
						e.physical_address, rsp.data.physical_address);
					errors++;
				end
				if (rsp.data.first_level_index !== e.first_level_index) begin
					$display("%0t: first_level_index expected %h actual %h", $time,
						e.first_level_index, rsp.data.first_level_index);
					errors++;
				end
				if (rsp.data.second_level_index !== e.second_level_index) begin
					$display("%0t: second_level_index expected %h actual %h", $time,
						e.second_level_index, rsp.data.second_level_index);
					errors++;
				end
				if (rsp.data.written_slot !== e.written_slot) begin
					$display("%0t: written_slot expected %h actual %h", $time,
						e.written_slot, rsp.data.written_slot);
					errors++;
				end
			end
		end
	end

	// Receiver stalls: a fresh wait is drawn after every transaction.
	always @(negedge clk) begin
		int w;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			recv_wait <= 0;
		end else if (rsp_taken) begin
			w = $urandom_range(0, 9);
			rsp.ready <= (w == 0);
			recv_wait <= (w == 0) ? 0 : w - 1;
		end else if (recv_wait > 0) begin
			recv_wait <= recv_wait - 1;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_idx = idx;
		cfg_val = val;
		cfg_go = 1'b1;
		@(posedge clk);
		while (!(cfg.valid && cfg.ready)) @(posedge clk);
		cfg_go = 1'b0;
	endtask

	task automatic drain_all();
		while (pending_reqs.size() > 0 || req.valid || expected_rsps.size() > 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_addr(int k);
		case (k)
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	// Traffic with a small set of pages so translates hit and fills recycle slots.
	task automatic queue_burst(int n);
		tlb_pkg::req_t r;
		logic [31:0] pages [8];
		logic [19:0] frames [6];
		for (int i = 0; i < 8; i++) pages[i] = $urandom();
		for (int i = 0; i < 6; i++) frames[i] = 20'($urandom());
		for (int i = 0; i < n; i++) begin
			r.mode = ($urandom_range(0, 99) < 45) ? tlb_pkg::MODE_TRANSLATE :
				($urandom_range(0, 99) < 92) ? tlb_pkg::MODE_FILL :
				($urandom_range(0, 1) ? tlb_pkg::MODE_FLUSH : tlb_pkg::MODE_UNUSED);
			r.logical_address = ($urandom_range(0, 9) < 8) ?
				pages[$urandom_range(0, 7)] ^ 32'($urandom_range(0, 255)) :
				pick_addr($urandom_range(0, 3));
			r.fill_frame = ($urandom_range(0, 3) != 0) ? frames[$urandom_range(0, 5)] :
				20'($urandom());
			pending_reqs.push_back(r);
		end
	endtask

	initial begin
		tlb_pkg::req_t r;
		errors = 0;
		cycles = 0;
		gap_left = 0;
		recv_wait = 0;
		cfg_go = 1'b0;
		cfg_idx = tlb_pkg::REG_PAGE_SIZE;
		cfg_val = '0;
		req_taken = 1'b0;
		cfg_taken = 1'b0;
		rsp_taken = 1'b0;
		req.valid = 1'b0;
		req.data = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		rsp.ready = 1'b0;
		pg_size_reg = 17'd64;
		per_table_reg = 11'd4;
		policy_reg = 1'b0;
		in_use_reg = 5'd4;
		evt_count = '0;
		for (int i = 0; i < tlb_pkg::MAX_ENTRIES; i++) begin
			tv_valid[i] = 1'b0;
			tv_page[i] = '0;
			tv_frame[i] = '0;
			tv_born[i] = '0;
			tv_touch[i] = '0;
		end
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed items at reset settings: every mode and field extreme.
		r = '{tlb_pkg::MODE_TRANSLATE, 32'h0, 20'h0};          pending_reqs.push_back(r);
		r = '{tlb_pkg::MODE_FILL, 32'h0, 20'h0};               pending_reqs.push_back(r);
		r = '{tlb_pkg::MODE_TRANSLATE, 32'h3F, 20'h0};         pending_reqs.push_back(r);
		r = '{tlb_pkg::MODE_FILL, 32'hFFFF_FFFF, 20'hF_FFFF};  pending_reqs.push_back(r);
		r = '{tlb_pkg::MODE_TRANSLATE, 32'hFFFF_FFFF, 20'h0};  pending_reqs.push_back(r);
		r = '{tlb_pkg::MODE_FILL, 32'h1000, 20'hF_FFFF};       pending_reqs.push_back(r);
		r = '{tlb_pkg::MODE_FILL, 32'h2000, 20'h1};            pending_reqs.push_back(r);
		r = '{tlb_pkg::MODE_FILL, 32'h3000, 20'h2};            pending_reqs.push_back(r);
		r = '{tlb_pkg::MODE_FILL, 32'h4000, 20'h3};            pending_reqs.push_back(r);
		r = '{tlb_pkg::MODE_TRANSLATE, 32'h2004, 20'h0};       pending_reqs.push_back(r);
		r = '{tlb_pkg::MODE_FILL, 32'h5000, 20'h4};            pending_reqs.push_back(r);
		r = '{tlb_pkg::MODE_UNUSED, 32'hFFFF_FFFF, 20'hF_FFFF}; pending_reqs.push_back(r);
		r = '{tlb_pkg::MODE_FLUSH, 32'hFFFF_FFFF, 20'hF_FFFF}; pending_reqs.push_back(r);
		r = '{tlb_pkg::MODE_TRANSLATE, 32'h2004, 20'h0};       pending_reqs.push_back(r);
		drain_all();

		// Zero and over-range registers, then LRU with all entries.
		write_reg(tlb_pkg::REG_PAGE_SIZE, 32'h0);
		write_reg(tlb_pkg::REG_PER_TABLE, 32'h0);
		write_reg(tlb_pkg::REG_IN_USE, 32'h0);
		write_reg(tlb_pkg::REG_POLICY, 32'h1);
		queue_burst(20);
		drain_all();
		write_reg(tlb_pkg::REG_PAGE_SIZE, 32'h1_FFFF);
		write_reg(tlb_pkg::REG_PER_TABLE, 32'h7FF);
		write_reg(tlb_pkg::REG_IN_USE, 32'h1F);
		queue_burst(20);
		drain_all();

		for (int ph = 0; ph < 16; ph++) begin
			case (ph % 4)
				0: write_reg(tlb_pkg::REG_PAGE_SIZE, 32'd65536);
				1: write_reg(tlb_pkg::REG_PAGE_SIZE, 32'd1);
				default: write_reg(tlb_pkg::REG_PAGE_SIZE, $urandom_range(1, 70000));
			endcase
			write_reg(tlb_pkg::REG_PER_TABLE, (ph % 3 == 0) ? 32'd1024 : $urandom_range(0, 1100));
			write_reg(tlb_pkg::REG_POLICY, ph % 2);
			write_reg(tlb_pkg::REG_IN_USE, (ph % 5 == 0) ? 32'd16 : $urandom_range(0, 20));
			queue_burst(100);
			drain_all();
		end

		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
